// ===== design/gpm_pkg.sv =====
// Shared types and constants of the glob pattern matcher.
package gpm_pkg;

	localparam int MAX_ELEMENTS = 16;
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

	localparam logic [1:0] OP_PAT_BYTE = 2'd0;
	localparam logic [1:0] OP_PAT_END  = 2'd1;
	localparam logic [1:0] OP_SUBJ     = 2'd2;
	localparam logic [1:0] OP_SUBJ_END = 2'd3;

	localparam logic [2:0] K_LIT    = 3'd0;
	localparam logic [2:0] K_ESC    = 3'd1;
	localparam logic [2:0] K_ANY    = 3'd2;
	localparam logic [2:0] K_STAR   = 3'd3;
	localparam logic [2:0] K_CLASS  = 3'd4;
	localparam logic [2:0] K_NCLASS = 3'd5;
	localparam logic [2:0] K_NEVER  = 3'd6;

	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef logic [2:0]             kind_t;
	typedef kind_t [MAX_ELEMENTS-1:0] kind_arr_t;
	typedef logic [MAX_ELEMENTS-1:0][7:0] char_arr_t;
	typedef logic [255:0]           cmap_t;
	typedef cmap_t [MAX_ELEMENTS-1:0] cmap_arr_t;
	typedef logic [CW-1:0]          cnt_t;
	typedef logic [MAX_ELEMENTS:0]  act_t;

	// Table status seen by the tracker; count and overflow updated for this request.
	typedef struct packed {
		cnt_t cnt;
		logic ovf;
		logic done;
	} tbl_stat_t;

endpackage

// ===== design/gpm_loader.sv =====
// Pattern loader: compiles pattern bytes into the element table.
module gpm_loader (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [1:0]         op,
	input  logic [7:0]         c,
	output gpm_pkg::kind_arr_t kind_n,
	output gpm_pkg::char_arr_t char_q,
	output gpm_pkg::cmap_arr_t cmap_q,
	output gpm_pkg::tbl_stat_t stat
);
	import gpm_pkg::*;

	localparam logic [2:0] PH_NORMAL = 3'd0;
	localparam logic [2:0] PH_ESC    = 3'd1;
	localparam logic [2:0] PH_CSTART = 3'd2;
	localparam logic [2:0] PH_CBODY  = 3'd3;
	localparam logic [2:0] PH_RANGE  = 3'd4;
	localparam logic [2:0] PH_DONE   = 3'd5;
	localparam logic [8:0] NO_PREV   = 9'd256;

	kind_arr_t  kind_q;
	char_arr_t  char_n;
	cmap_arr_t  cmap_n;
	cnt_t       cnt_q, cnt_e, cnt_n;
	logic       ovf_q, ovf_e, ovf_n;
	logic [2:0] ph_q, ph_e, ph_n;
	logic [8:0] prev_q, prev_e, prev_n;
	logic       start, add_en, rng_en, inv_en;
	kind_t      add_kind;
	logic [7:0] add_ch, rng_lo, rng_hi;
	cnt_t       last;
	cmap_t      rng_mask;

	always_comb begin
		start = (op == OP_PAT_BYTE || op == OP_PAT_END) && ph_q == PH_DONE;
		cnt_e  = start ? '0 : cnt_q;
		ovf_e  = start ? 1'b0 : ovf_q;
		ph_e   = start ? PH_NORMAL : ph_q;
		prev_e = start ? NO_PREV : prev_q;

		ph_n = ph_e;
		prev_n = prev_e;
		add_en = 1'b0;
		add_kind = K_LIT;
		add_ch = c;
		rng_en = 1'b0;
		rng_lo = c;
		rng_hi = c;
		inv_en = 1'b0;

		case (op)
			OP_PAT_BYTE: begin
				case (ph_e)
					PH_ESC: begin
						add_en = 1'b1;
						add_kind = K_ESC;
						ph_n = PH_NORMAL;
					end
					PH_CSTART, PH_CBODY: begin
						if (ph_e == PH_CSTART && c == "^") begin
							inv_en = 1'b1;
							ph_n = PH_CBODY;
						end else if (c == "]") begin
							ph_n = PH_NORMAL;
						end else if (c == "-") begin
							ph_n = PH_RANGE;
						end else begin
							rng_en = 1'b1;
							prev_n = {1'b0, c};
							ph_n = PH_CBODY;
						end
					end
					PH_RANGE: begin
						rng_en = (prev_e != NO_PREV);
						rng_lo = prev_e[7:0];
						prev_n = {1'b0, c};
						ph_n = PH_CBODY;
					end
					default: begin
						if (c == "\\") begin
							ph_n = PH_ESC;
						end else begin
							add_en = 1'b1;
							add_ch = 8'd0;
							if (c == "?") begin
								add_kind = K_ANY;
							end else if (c == "*") begin
								add_kind = K_STAR;
							end else if (c == "[") begin
								add_kind = K_CLASS;
								prev_n = NO_PREV;
								ph_n = PH_CSTART;
							end else begin
								add_kind = K_LIT;
								add_ch = c;
							end
						end
					end
				endcase
			end
			default: begin
				// End of pattern, or a subject request that closes an open pattern.
				if (op == OP_PAT_END || ph_e != PH_DONE) begin
					add_en = (ph_e == PH_ESC);
					add_kind = K_NEVER;
					add_ch = 8'd0;
					ph_n = PH_DONE;
					prev_n = NO_PREV;
				end
			end
		endcase

		for (int v = 0; v < 256; v++) begin
			rng_mask[v] = (rng_lo <= 8'(v)) && (8'(v) <= rng_hi);
		end

		kind_n = kind_q;
		char_n = char_q;
		cmap_n = cmap_q;
		cnt_n = cnt_e;
		ovf_n = ovf_e;
		last = cnt_t'(cnt_e - cnt_t'(1));

		if (add_en) begin
			if (cnt_e < cnt_t'(MAX_ELEMENTS)) begin
				kind_n[cnt_e[IW-1:0]] = add_kind;
				char_n[cnt_e[IW-1:0]] = add_ch;
				if (add_kind == K_CLASS) begin
					cmap_n[cnt_e[IW-1:0]] = '0;
				end
				cnt_n = cnt_t'(cnt_e + cnt_t'(1));
			end else begin
				ovf_n = 1'b1;
			end
		end
		if (rng_en && !ovf_e && cnt_e != '0) begin
			cmap_n[last[IW-1:0]] = cmap_q[last[IW-1:0]] | rng_mask;
		end
		if (inv_en && !ovf_e && cnt_e != '0) begin
			kind_n[last[IW-1:0]] = K_NCLASS;
		end
	end

	assign stat = '{cnt: cnt_n, ovf: ovf_n, done: (ph_q == PH_DONE)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			ph_q <= PH_NORMAL;
			prev_q <= NO_PREV;
		end else if (step) begin
			cnt_q <= cnt_n;
			ovf_q <= ovf_n;
			ph_q <= ph_n;
			prev_q <= prev_n;
		end
	end

	// Table contents are only read below the element count.
	always_ff @(posedge clk) begin
		if (step) begin
			kind_q <= kind_n;
			char_q <= char_n;
			cmap_q <= cmap_n;
		end
	end

endmodule

// ===== design/gpm_tracker.sv =====
// Subject tracker: active position vector and match decision.
module gpm_tracker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [1:0]         op,
	input  logic [7:0]         c,
	input  gpm_pkg::kind_arr_t kinds,
	input  gpm_pkg::char_arr_t chars,
	input  gpm_pkg::cmap_arr_t cmaps,
	input  gpm_pkg::tbl_stat_t stat,
	output logic               matched
);
	import gpm_pkg::*;

	act_t                    raw_q, raw_e, raw_n, closed, nxt;
	logic                    acc_q, acc_e, acc_n;
	logic [MAX_ELEMENTS-1:0] live, star, hit;
	logic                    at_end;

	always_comb begin
		// An open pattern gets closed by this request: restart from position zero.
		raw_e = stat.done ? raw_q : act_t'(1);
		acc_e = stat.done ? acc_q : 1'b0;

		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			live[i] = cnt_t'(i) < stat.cnt;
			star[i] = kinds[i] == K_STAR;
			case (kinds[i])
				K_LIT, K_ESC: hit[i] = chars[i] == c;
				K_ANY:        hit[i] = 1'b1;
				K_CLASS:      hit[i] = cmaps[i][c];
				K_NCLASS:     hit[i] = !cmaps[i][c];
				default:      hit[i] = 1'b0;
			endcase
		end

		// Stars let an active position fall through to the next one.
		closed[0] = raw_e[0];
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			closed[i+1] = raw_e[i+1] | (closed[i] & live[i] & star[i]);
		end

		nxt[0] = closed[0] & live[0] & star[0];
		for (int i = 1; i <= MAX_ELEMENTS; i++) begin
			nxt[i] = closed[i-1] & live[i-1] & !star[i-1] & hit[i-1];
			if (i < MAX_ELEMENTS) begin
				nxt[i] = nxt[i] | (closed[i] & live[i] & star[i]);
			end
		end

		at_end = closed[stat.cnt];
		matched = (acc_e | at_end) & !stat.ovf;

		raw_n = act_t'(1);
		acc_n = 1'b0;
		if (op == OP_SUBJ) begin
			raw_n = nxt;
			acc_n = acc_e | (at_end & (c == CH_SLASH));
		end else if (op == OP_PAT_BYTE) begin
			raw_n = raw_q;
			acc_n = acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= act_t'(1);
			acc_q <= 1'b0;
		end else if (step) begin
			raw_q <= raw_n;
			acc_q <= acc_n;
		end
	end

endmodule

// ===== design/glob_pattern_matcher.sv =====
// Top level of the glob pattern matcher: request register, loader, tracker, result register.
// Path: a request is held in the request register, processed from there by loader and tracker,
//   and an end-of-subject result is loaded into the output register.
// Throughput: one request per cycle; only a held result stalls end-of-subject requests.
// Reset (arst_n low, asynchronous): empty pattern loaded, position zero active, no result.
module glob_pattern_matcher (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       matched,
	output logic       pattern_overflow
);
	import gpm_pkg::*;

	logic       v_s1, step, match_c;
	logic [1:0] op_s1;
	logic [7:0] byte_s1;
	kind_arr_t  kinds;
	char_arr_t  chars;
	cmap_arr_t  cmaps;
	tbl_stat_t  stat;

	// Advance the held request unless it is a result request and the output is still full.
	assign step = v_s1 && (op_s1 != OP_SUBJ_END || !out_valid || out_ready);
	assign in_ready = !v_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1 <= opcode;
			byte_s1 <= data_byte;
		end
	end

	gpm_loader u_loader (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.op     (op_s1),
		.c      (byte_s1),
		.kind_n (kinds),
		.char_q (chars),
		.cmap_q (cmaps),
		.stat   (stat)
	);

	gpm_tracker u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.op      (op_s1),
		.c       (byte_s1),
		.kinds   (kinds),
		.chars   (chars),
		.cmaps   (cmaps),
		.stat    (stat),
		.matched (match_c)
	);

	// Result register: load on end of subject, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (step && op_s1 == OP_SUBJ_END) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && op_s1 == OP_SUBJ_END) begin
			matched <= match_c;
			pattern_overflow <= stat.ovf;
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Testbench for the glob pattern matcher: directed and random requests checked against a predictor.
module testbench;
	import gpm_pkg::*;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
	} req_t;

	typedef struct packed {
		logic hit;
		logic ovf;
	} verdict_t;

	// loader phases of the predictor
	typedef enum logic [2:0] {
		LD_NORMAL, LD_ESC, LD_CSTART, LD_CBODY, LD_RANGE, LD_DONE
	} ld_phase_t;

	localparam logic [8:0] NO_PREV = 9'd256;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic out_valid;
	logic out_ready;
	logic matched;
	logic pattern_overflow;

	glob_pattern_matcher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.matched(matched),
		.pattern_overflow(pattern_overflow)
	);

	// predictor state
	kind_t pk_kind [MAX_ELEMENTS];
	logic [7:0] pk_char [MAX_ELEMENTS];
	logic [255:0] pk_map [MAX_ELEMENTS];
	int pk_count;
	ld_phase_t pk_phase;
	logic [8:0] pk_prev;
	logic pk_ovf;
	logic [MAX_ELEMENTS:0] pk_act;
	logic pk_accept;

	req_t pending_requests[$];
	verdict_t expected_verdicts[$];
	int errors;
	logic stim_done;

	always #10 clk = ~clk;

	function automatic void add_elem(kind_t k, logic [7:0] c);
		if (pk_count < MAX_ELEMENTS) begin
			pk_kind[pk_count] = k;
			pk_char[pk_count] = c;
			if (k == K_CLASS)
				pk_map[pk_count] = '0;
			pk_count++;
		end else
			pk_ovf = 1'b1;
	endfunction

	function automatic void set_range(int lo, int hi);
		if (pk_ovf || pk_count == 0)
			return;
		for (int v = lo; v <= hi && v < 256; v++)
			pk_map[pk_count - 1][v] = 1'b1;
	endfunction

	// let every active star also enable the position after it
	function automatic void spread_stars();
		for (int i = 0; i < pk_count; i++)
			if (pk_act[i] && pk_kind[i] == K_STAR)
				pk_act[i + 1] = 1'b1;
	endfunction

	function automatic void restart_subject();
		pk_act = '0;
		pk_act[0] = 1'b1;
		pk_accept = 1'b0;
		spread_stars();
	endfunction

	function automatic void start_pattern();
		pk_count = 0;
		pk_ovf = 1'b0;
		pk_phase = LD_NORMAL;
		pk_prev = NO_PREV;
	endfunction

	function automatic void close_pattern();
		if (pk_phase == LD_ESC)
			add_elem(K_NEVER, 8'd0);
		pk_phase = LD_DONE;
		pk_prev = NO_PREV;
		restart_subject();
	endfunction

	function automatic void class_byte(logic [7:0] c);
		if (c == "]")
			pk_phase = LD_NORMAL;
		else if (c == "-")
			pk_phase = LD_RANGE;
		else begin
			set_range(c, c);
			pk_prev = {1'b0, c};
			pk_phase = LD_CBODY;
		end
	endfunction

	function automatic void load_pattern_byte(logic [7:0] c);
		case (pk_phase)
			LD_ESC: begin
				add_elem(K_ESC, c);
				pk_phase = LD_NORMAL;
			end
			LD_CSTART: begin
				if (c == "^") begin
					if (!pk_ovf && pk_count > 0)
						pk_kind[pk_count - 1] = K_NCLASS;
					pk_phase = LD_CBODY;
				end else
					class_byte(c);
			end
			LD_CBODY: class_byte(c);
			LD_RANGE: begin
				if (pk_prev < NO_PREV)
					set_range(pk_prev, c);
				pk_prev = {1'b0, c};
				pk_phase = LD_CBODY;
			end
			default: begin
				if (c == "\\")
					pk_phase = LD_ESC;
				else if (c == "?")
					add_elem(K_ANY, 8'd0);
				else if (c == "*")
					add_elem(K_STAR, 8'd0);
				else if (c == "[") begin
					add_elem(K_CLASS, 8'd0);
					pk_prev = NO_PREV;
					pk_phase = LD_CSTART;
				end else
					add_elem(K_LIT, c);
			end
		endcase
	endfunction

	function automatic logic elem_hit(int i, logic [7:0] c);
		case (pk_kind[i])
			K_LIT, K_ESC: return pk_char[i] == c;
			K_ANY: return 1'b1;
			K_CLASS: return pk_map[i][c];
			K_NCLASS: return !pk_map[i][c];
			default: return 1'b0;
		endcase
	endfunction

	function automatic void advance_subject(logic [7:0] c);
		logic [MAX_ELEMENTS:0] nxt;
		nxt = '0;
		for (int i = 0; i < pk_count; i++) begin
			if (!pk_act[i])
				continue;
			if (pk_kind[i] == K_STAR)
				nxt[i] = 1'b1;
			else if (elem_hit(i, c))
				nxt[i + 1] = 1'b1;
		end
		pk_act = nxt;
		spread_stars();
	endfunction

	// apply one accepted request, queue a verdict at end of subject
	function automatic void predict_match(req_t r);
		verdict_t v;
		if (r.op == OP_PAT_BYTE || r.op == OP_PAT_END) begin
			if (pk_phase == LD_DONE)
				start_pattern();
			if (r.op == OP_PAT_BYTE)
				load_pattern_byte(r.ch);
			else
				close_pattern();
			return;
		end
		if (pk_phase != LD_DONE)
			close_pattern();
		if (r.op == OP_SUBJ) begin
			if (pk_act[pk_count] && r.ch == CH_SLASH)
				pk_accept = 1'b1;
			advance_subject(r.ch);
			return;
		end
		v.hit = (pk_accept || pk_act[pk_count]) && !pk_ovf;
		v.ovf = pk_ovf;
		expected_verdicts = {expected_verdicts, v};
		restart_subject();
	endfunction

	// stimulus builders
	task automatic push_req(logic [1:0] op, logic [7:0] ch);
		req_t r;
		r.op = op;
		r.ch = ch;
		pending_requests = {pending_requests, r};
	endtask

	task automatic push_pattern(string s);
		for (int i = 0; i < s.len(); i++)
			push_req(OP_PAT_BYTE, s[i]);
		push_req(OP_PAT_END, 8'($urandom));
	endtask

	task automatic push_subject(string s);
		for (int i = 0; i < s.len(); i++)
			push_req(OP_SUBJ, s[i]);
		push_req(OP_SUBJ_END, 8'($urandom));
	endtask

	function automatic logic [7:0] pick_char();
		logic [7:0] alpha [12] = '{"a", "b", "c", "/", "*", "?", "[", "]", "^", "-", "\\", "z"};
		if ($urandom_range(0, 9) == 0)
			return 8'($urandom);
		return alpha[$urandom_range(0, 11)];
	endfunction

	function automatic string rand_text(int len);
		string s;
		s = "";
		for (int i = 0; i < len; i++)
			s = {s, string'(pick_char())};
		return s;
	endfunction

	// a subject built to fit the pattern often, with random bytes mixed in
	function automatic string subject_for(string pat);
		string s;
		s = "";
		for (int i = 0; i < pat.len(); i++) begin
			case (pat[i])
				"*": s = {s, rand_text($urandom_range(0, 2))};
				"?": s = {s, string'(pick_char())};
				"[", "]", "^", "-", "\\": s = {s, string'(pick_char())};
				default: s = {s, string'(pat[i])};
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			s = {s, "/", rand_text($urandom_range(0, 3))};
		if ($urandom_range(0, 4) == 0 && s.len() > 0)
			s[$urandom_range(0, s.len() - 1)] = pick_char();
		return s;
	endfunction

	initial begin
		string pat;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_PAT_BYTE;
		data_byte = 8'd0;
		out_ready = 1'b0;
		errors = 0;
		stim_done = 1'b0;
		start_pattern();
		restart_subject();

		// directed: empty pattern, extremes, each element kind
		push_subject("");
		push_subject("a");
		push_req(OP_PAT_BYTE, 8'h00);
		push_req(OP_PAT_BYTE, 8'hFF);
		push_req(OP_SUBJ, 8'h00);
		push_req(OP_SUBJ, 8'hFF);
		push_req(OP_SUBJ_END, 8'hFF);
		push_pattern("a*[b-d]?");
		push_subject("axxcq");
		push_subject("ab/c");
		push_pattern("[^]x]");
		push_subject("y");
		push_subject("");
		push_pattern("[-a]\\*");
		push_subject("a*");
		push_pattern("[a-");
		push_subject("a");
		push_pattern("ab\\");
		push_subject("ab");
		push_pattern("abcdefghijklmnopq");
		push_subject("abcdefghijklmnopq");
		push_req(OP_PAT_END, 8'd0);
		push_req(OP_PAT_END, 8'd0);
		push_subject("");

		while (pending_requests.size() < 1800) begin
			case ($urandom_range(0, 9))
				0: push_req(2'($urandom), 8'($urandom));
				1: push_pattern(rand_text($urandom_range(10, 20)));
				default: begin
					pat = rand_text($urandom_range(0, 8));
					push_pattern(pat);
					repeat ($urandom_range(1, 4))
						push_subject(subject_for(pat));
				end
			endcase
		end
		push_req(OP_SUBJ_END, 8'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		stim_done = 1'b1;
	end

	// driver: bursts of requests with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_match('{op: opcode, ch: data_byte});
				void'(pending_requests.pop_front());
			end
			// hold the request until accepted
			if (!(in_valid && !in_ready)) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_requests.size() > ((in_valid && in_ready) ? 1 : 0)) begin
					req_t r;
					r = pending_requests[(in_valid && in_ready) ? 1 : 0];
					in_valid <= 1'b1;
					opcode <= r.op;
					data_byte <= r.ch;
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else
						burst_left <= burst_left - 1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result, stall the result channel on its own pattern
	int stall_phase;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_phase <= 0;
		else begin
			stall_phase <= stall_phase + 1;
			out_ready <= ((stall_phase / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
			if (out_valid && out_ready) begin
				if (expected_verdicts.size() == 0) begin
					$error("unexpected result matched=%0b pattern_overflow=%0b",
						matched, pattern_overflow);
					errors++;
				end else begin
					verdict_t e;
					e = expected_verdicts.pop_front();
					if (matched !== e.hit) begin
						$error("matched: expected %0b, got %0b", e.hit, matched);
						errors++;
					end
					if (pattern_overflow !== e.ovf) begin
						$error("pattern_overflow: expected %0b, got %0b", e.ovf, pattern_overflow);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (pending_requests.size() == 0 && !in_valid);
		wait (expected_verdicts.size() == 0);
		repeat (10) @(posedge clk);
		if (errors == 0 && expected_verdicts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end

endmodule
